FILE: hw/rtl/fdtp_pkg.sv
// fdtp_pkg: types, constants and the sequencer program of the F tail probability block
// depends on nothing; imported by f_distribution_tail_probability and fdtp_checker
package fdtp_pkg;

	localparam logic [7:0] MaxDf     = 8'd255;
	localparam int         AtanTerms = 12;
	localparam int         PcW       = 7;
	localparam int         RfDepth   = 16;

	localparam logic signed [63:0] QZero = 64'sh0;
	localparam logic signed [63:0] QOne  = 64'sh0000_0100_0000_0000;
	localparam logic signed [63:0] QHalf = 64'sh0000_0080_0000_0000;
	localparam logic signed [63:0] QTwo  = 64'sh0000_0200_0000_0000;
	localparam logic signed [63:0] QFour = 64'sh0000_0400_0000_0000;
	localparam logic signed [63:0] QMax  = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] InvPiNum = 64'sd3183098862;
	localparam logic signed [63:0] InvPiDen = 64'sd10000000000;
	localparam logic [31:0]        ProbOne  = 32'h8000_0000;

	typedef logic [PcW-1:0] pc_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_FETCH, ST_LOAD, ST_MUL, ST_DIV, ST_SQRT, ST_WB, ST_OUT
	} fsm_t;

	typedef enum logic [3:0] {
		OP_MUL, OP_DIV, OP_SQRT, OP_ADD, OP_SUB, OP_ADDSUBK, OP_CMPLE, OP_JMP,
		OP_SETJ, OP_SETI, OP_SETK, OP_INCJ, OP_INCI, OP_INCK, OP_DONE
	} op_t;

	typedef enum logic [3:0] {
		R_T1, R_W, R_Z, R_Y, R_D, R_P, R_C, R_CC, R_X, R_S, R_TERM, R_SUM, R_T2SQ
	} rf_idx_t;

	typedef enum logic [4:0] {
		A_T1 = 5'd0, A_W = 5'd1, A_Z = 5'd2, A_Y = 5'd3, A_D = 5'd4, A_P = 5'd5,
		A_C = 5'd6, A_CC = 5'd7, A_X = 5'd8, A_S = 5'd9, A_TERM = 5'd10,
		A_SUM = 5'd11, A_T2SQ = 5'd12,
		K_ZERO = 5'd16, K_ONE, K_HALF, K_TWO, K_FOUR, K_C1, K_C2, K_FV, K_M, K_N,
		K_A, K_JM2, K_JM1, K_JJ, K_IM2, K_ODD
	} src_t;

	typedef enum logic [3:0] {
		C_ALWAYS, C_NOT_OO, C_NOT_A1, C_NOT_B1, C_FLAG, C_J_GT_N, C_J_LE_N,
		C_I_GT_M, C_I_LE_M, C_K_LT
	} cond_t;

	typedef struct packed {
		op_t     op;
		rf_idx_t dst;
		src_t    sa;
		src_t    sb;
		cond_t   cond;
		pc_t     tgt;
	} instr_t;

	localparam pc_t LA1  = 7'd39;
	localparam pc_t LB1  = 7'd46;
	localparam pc_t LEE  = 7'd52;
	localparam pc_t LY   = 7'd54;
	localparam pc_t L2   = 7'd71;
	localparam pc_t LEND = 7'd83;

	function automatic instr_t ar(op_t o, rf_idx_t d, src_t a, src_t b);
		instr_t r;
		r = '{op: o, dst: d, sa: a, sb: b, cond: C_ALWAYS, tgt: '0};
		return r;
	endfunction

	function automatic instr_t jp(cond_t c, pc_t t);
		instr_t r;
		r = '{op: OP_JMP, dst: R_T1, sa: A_T1, sb: A_T1, cond: c, tgt: t};
		return r;
	endfunction

	function automatic instr_t ct(op_t o);
		instr_t r;
		r = '{op: o, dst: R_T1, sa: A_T1, sb: A_T1, cond: C_ALWAYS, tgt: '0};
		return r;
	endfunction

	function automatic instr_t prog(pc_t pc);
		instr_t r;
		case (pc)
			7'd0:  r = ar(OP_MUL, R_T1, K_FV, K_M);
			7'd1:  r = ar(OP_DIV, R_W, A_T1, K_N);
			7'd2:  r = ar(OP_ADD, R_T1, K_ONE, A_W);
			7'd3:  r = ar(OP_DIV, R_Z, K_ONE, A_T1);
			7'd4:  r = jp(C_NOT_OO, LA1);
			// both degrees odd
			7'd5:  r = ar(OP_DIV, R_C, K_C1, K_C2);
			7'd6:  r = ar(OP_SQRT, R_P, A_W, A_W);
			7'd7:  r = ar(OP_MUL, R_T1, A_C, A_Z);
			7'd8:  r = ar(OP_DIV, R_D, A_T1, A_P);
			7'd9:  r = ar(OP_ADD, R_CC, A_C, A_C);
			7'd10: r = ar(OP_CMPLE, R_T1, A_P, K_ONE);
			7'd11: r = ar(OP_ADD, R_X, A_P, K_ZERO);
			7'd12: r = jp(C_FLAG, 7'd14);
			7'd13: r = ar(OP_DIV, R_X, K_ONE, A_P);
			7'd14: r = ar(OP_MUL, R_T1, A_X, A_X);
			7'd15: r = ar(OP_ADD, R_T1, K_ONE, A_T1);
			7'd16: r = ar(OP_SQRT, R_S, A_T1, A_T1);
			7'd17: r = ar(OP_ADD, R_S, K_ONE, A_S);
			7'd18: r = ar(OP_DIV, R_X, A_X, A_S);
			7'd19: r = ar(OP_MUL, R_T1, A_X, A_X);
			7'd20: r = ar(OP_ADD, R_T1, K_ONE, A_T1);
			7'd21: r = ar(OP_SQRT, R_S, A_T1, A_T1);
			7'd22: r = ar(OP_ADD, R_S, K_ONE, A_S);
			7'd23: r = ar(OP_DIV, R_X, A_X, A_S);
			7'd24: r = ar(OP_MUL, R_T2SQ, A_X, A_X);
			7'd25: r = ar(OP_ADD, R_TERM, A_X, K_ZERO);
			7'd26: r = ar(OP_ADD, R_SUM, K_ZERO, K_ZERO);
			7'd27: r = ct(OP_SETK);
			7'd28: r = ar(OP_DIV, R_T1, A_TERM, K_ODD);
			7'd29: r = ar(OP_ADDSUBK, R_SUM, A_SUM, A_T1);
			7'd30: r = ar(OP_MUL, R_TERM, A_TERM, A_T2SQ);
			7'd31: r = ct(OP_INCK);
			7'd32: r = jp(C_K_LT, 7'd28);
			7'd33: r = ar(OP_MUL, R_SUM, A_SUM, K_FOUR);
			7'd34: r = ar(OP_MUL, R_T1, A_CC, A_SUM);
			7'd35: r = ar(OP_ADD, R_P, A_T1, K_ZERO);
			7'd36: r = jp(C_FLAG, LY);
			7'd37: r = ar(OP_SUB, R_P, K_ONE, A_T1);
			7'd38: r = jp(C_ALWAYS, LY);
			// numerator odd, denominator even
			7'd39: r = jp(C_NOT_A1, LB1);
			7'd40: r = ar(OP_MUL, R_T1, A_W, A_Z);
			7'd41: r = ar(OP_SQRT, R_P, A_T1, A_T1);
			7'd42: r = ar(OP_MUL, R_T1, K_HALF, A_P);
			7'd43: r = ar(OP_MUL, R_T1, A_T1, A_Z);
			7'd44: r = ar(OP_DIV, R_D, A_T1, A_W);
			7'd45: r = jp(C_ALWAYS, LY);
			// numerator even, denominator odd
			7'd46: r = jp(C_NOT_B1, LEE);
			7'd47: r = ar(OP_SQRT, R_P, A_Z, A_Z);
			7'd48: r = ar(OP_MUL, R_T1, K_HALF, A_Z);
			7'd49: r = ar(OP_MUL, R_D, A_T1, A_P);
			7'd50: r = ar(OP_SUB, R_P, K_ONE, A_P);
			7'd51: r = jp(C_ALWAYS, LY);
			// both even
			7'd52: r = ar(OP_MUL, R_D, A_Z, A_Z);
			7'd53: r = ar(OP_MUL, R_P, A_W, A_Z);
			// denominator recurrence
			7'd54: r = ar(OP_ADD, R_T1, A_W, A_W);
			7'd55: r = ar(OP_DIV, R_Y, A_T1, A_Z);
			7'd56: r = ct(OP_SETJ);
			7'd57: r = jp(C_J_GT_N, L2);
			7'd58: r = ar(OP_DIV, R_T1, K_A, K_JM2);
			7'd59: r = ar(OP_ADD, R_T1, K_ONE, A_T1);
			7'd60: r = ar(OP_MUL, R_T1, A_T1, A_Z);
			7'd61: r = ar(OP_MUL, R_D, A_D, A_T1);
			7'd62: r = jp(C_NOT_A1, 7'd67);
			7'd63: r = ar(OP_MUL, R_T1, A_D, A_Y);
			7'd64: r = ar(OP_DIV, R_T1, A_T1, K_JM1);
			7'd65: r = ar(OP_ADD, R_P, A_P, A_T1);
			7'd66: r = jp(C_ALWAYS, 7'd69);
			7'd67: r = ar(OP_ADD, R_T1, A_P, A_W);
			7'd68: r = ar(OP_MUL, R_P, A_T1, A_Z);
			7'd69: r = ct(OP_INCJ);
			7'd70: r = jp(C_J_LE_N, 7'd58);
			// numerator recurrence
			7'd71: r = ar(OP_MUL, R_Y, A_W, A_Z);
			7'd72: r = ar(OP_DIV, R_Z, K_TWO, A_Z);
			7'd73: r = ct(OP_SETI);
			7'd74: r = jp(C_I_GT_M, LEND);
			7'd75: r = ar(OP_MUL, R_T1, A_Y, K_JJ);
			7'd76: r = ar(OP_DIV, R_T1, A_T1, K_IM2);
			7'd77: r = ar(OP_MUL, R_D, A_D, A_T1);
			7'd78: r = ar(OP_MUL, R_T1, A_Z, A_D);
			7'd79: r = ar(OP_DIV, R_T1, A_T1, K_JJ);
			7'd80: r = ar(OP_SUB, R_P, A_P, A_T1);
			7'd81: r = ct(OP_INCI);
			7'd82: r = jp(C_I_LE_M, 7'd75);
			7'd83: r = ar(OP_SUB, R_T1, K_ONE, A_P);
			default: r = ar(OP_DONE, R_T1, A_T1, A_T1);
		endcase
		return r;
	endfunction

endpackage

FILE: hw/rtl/f_distribution_tail_probability.sv
// f_distribution_tail_probability: upper-tail probability of the F distribution
// a zero statistic or zero degree is answered without running the program; the multiply,
// square root and divide are iterative units, the divider bit-serial
// handshake: a new beat is taken only once the last result is accepted, in_ready only while idle
// reset: arst_n returns the sequencer to idle; the register file is not cleared
module f_distribution_tail_probability
	import fdtp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] f_value,
	input  logic [7:0]  num_df,
	input  logic [7:0]  den_df,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] tail_prob
);

	localparam logic signed [64:0] SMax = 65'sh0_7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [64:0] SMin = -65'sh0_7FFF_FFFF_FFFF_FFFF;

	fsm_t state_q, state_d;
	instr_t ins;
	logic cond_ok;

	logic [31:0] fv_q;
	logic [7:0]  m_q, n_q, m_in, n_in;
	logic        a1_q, b1_q, flag_q;
	pc_t         pc_q;
	logic [8:0]  j_q, i_q;
	logic [3:0]  k_q;
	logic [31:0] out_q;

	logic signed [63:0] rf_mem [RfDepth];
	logic signed [63:0] rda_q, rdb_q, opa, opb;
	logic               rf_we;
	logic signed [63:0] rf_wdata;

	logic [63:0]  mag_a_q, mag_b_q;
	logic         neg_q, a_zero_q, over_q;
	logic [63:0]  pp_q, quo_q;
	logic [127:0] acc_q, dvd_q;
	logic [64:0]  rem_q;
	logic [7:0]   cnt_q;

	logic [31:0]  mxa, mxb;
	logic [127:0] pp_sh, prod;
	logic [63:0]  mag_res;
	logic signed [63:0] unit_res, addsub_res;
	logic [64:0]  dr2;
	logic         dge;
	logic [66:0]  sr2, strial;
	logic         sge;
	logic [8:0]   jm2, jm1, im2;
	logic [9:0]   jj;
	logic [4:0]   odd;
	logic [40:0]  clamp41;
	logic [41:0]  rnd;
	logic         special;

	function automatic logic [63:0] mag(logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
		logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > SMax) return QMax;
		if (s < SMin) return -QMax;
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] pick(src_t s, logic signed [63:0] rd);
		logic signed [63:0] v;
		case (s)
			K_ZERO: v = QZero;
			K_ONE:  v = QOne;
			K_HALF: v = QHalf;
			K_TWO:  v = QTwo;
			K_FOUR: v = QFour;
			K_C1:   v = InvPiNum;
			K_C2:   v = InvPiDen;
			K_FV:   v = {8'd0, fv_q, 24'd0};
			K_M:    v = {16'd0, m_q, 40'd0};
			K_N:    v = {16'd0, n_q, 40'd0};
			K_A:    v = {22'd0, (a1_q ? 2'd1 : 2'd2), 40'd0};
			K_JM2:  v = {15'd0, jm2, 40'd0};
			K_JM1:  v = {15'd0, jm1, 40'd0};
			K_JJ:   v = {14'd0, jj, 40'd0};
			K_IM2:  v = {15'd0, im2, 40'd0};
			K_ODD:  v = {19'd0, odd, 40'd0};
			default: v = rd;
		endcase
		return v;
	endfunction

	assign ins     = prog(pc_q);
	assign m_in    = (num_df > MaxDf) ? MaxDf : num_df;
	assign n_in    = (den_df > MaxDf) ? MaxDf : den_df;
	assign special = (f_value == '0) || (m_in == '0) || (n_in == '0);

	assign jm2 = j_q - 9'd2;
	assign jm1 = j_q - 9'd1;
	assign im2 = i_q - 9'd2;
	assign jj  = {1'b0, i_q} + {2'b0, n_q} - 10'd2;
	assign odd = {k_q, 1'b1};

	always_comb begin
		opa = pick(ins.sa, rda_q);
		opb = pick(ins.sb, rdb_q);
	end

	always_comb begin
		case (ins.cond)
			C_ALWAYS: cond_ok = 1'b1;
			C_NOT_OO: cond_ok = !(a1_q && b1_q);
			C_NOT_A1: cond_ok = !a1_q;
			C_NOT_B1: cond_ok = !b1_q;
			C_FLAG:   cond_ok = flag_q;
			C_J_GT_N: cond_ok = j_q > {1'b0, n_q};
			C_J_LE_N: cond_ok = j_q <= {1'b0, n_q};
			C_I_GT_M: cond_ok = i_q > {1'b0, m_q};
			C_I_LE_M: cond_ok = i_q <= {1'b0, m_q};
			C_K_LT:   cond_ok = k_q < 4'(AtanTerms);
			default:  cond_ok = 1'b0;
		endcase
	end

	// multiplier partial products
	always_comb begin
		case (cnt_q[1:0])
			2'd0: begin mxa = mag_a_q[31:0];  mxb = mag_b_q[31:0];  end
			2'd1: begin mxa = mag_a_q[31:0];  mxb = mag_b_q[63:32]; end
			2'd2: begin mxa = mag_a_q[63:32]; mxb = mag_b_q[31:0];  end
			default: begin mxa = mag_a_q[63:32]; mxb = mag_b_q[63:32]; end
		endcase
		case (cnt_q[2:0])
			3'd1:      pp_sh = {64'd0, pp_q};
			3'd2, 3'd3: pp_sh = {32'd0, pp_q, 32'd0};
			default:   pp_sh = {pp_q, 64'd0};
		endcase
	end

	// divider and square root steps
	always_comb begin
		dr2    = {rem_q[63:0], dvd_q[127]};
		dge    = dr2 >= {1'b0, mag_b_q};
		sr2    = {rem_q, dvd_q[127:126]};
		strial = {1'b0, quo_q, 2'b01};
		sge    = sr2 >= strial;
	end

	// unit result at write-back
	always_comb begin
		prod    = acc_q + (128'd1 << 39);
		mag_res = '0;
		case (ins.op)
			OP_MUL: begin
				if (prod[127:103] != '0 || prod[103]) mag_res = QMax;
				else mag_res = prod[103:40];
			end
			OP_DIV: begin
				if (over_q || quo_q[63]) mag_res = QMax;
				else mag_res = quo_q;
			end
			default: mag_res = quo_q;
		endcase
		if (ins.op == OP_DIV && mag_b_q == '0) begin
			unit_res = a_zero_q ? QZero : (neg_q ? -QMax : QMax);
		end else begin
			unit_res = (neg_q && ins.op != OP_SQRT) ? -$signed(mag_res) : $signed(mag_res);
		end
	end

	always_comb begin
		case (ins.op)
			OP_SUB:     addsub_res = sat_add(opa, -opb);
			OP_ADDSUBK: addsub_res = k_q[0] ? sat_add(opa, -opb) : sat_add(opa, opb);
			default:    addsub_res = sat_add(opa, opb);
		endcase
	end

	always_comb begin
		clamp41 = opa[63] ? 41'd0 : ((opa > QOne) ? QOne[40:0] : opa[40:0]);
		rnd     = {1'b0, clamp41} + 42'd256;
	end

	always_comb begin
		rf_we    = 1'b0;
		rf_wdata = addsub_res;
		if (state_q == ST_LOAD) begin
			rf_we = ins.op inside {OP_ADD, OP_SUB, OP_ADDSUBK};
		end else if (state_q == ST_WB) begin
			rf_we    = 1'b1;
			rf_wdata = unit_res;
		end
	end

	always_ff @(posedge clk) begin
		if (rf_we) rf_mem[ins.dst] <= rf_wdata;
		rda_q <= rf_mem[ins.sa[3:0]];
		rdb_q <= rf_mem[ins.sb[3:0]];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = special ? ST_OUT : ST_FETCH;
			ST_FETCH: begin
				case (ins.op)
					OP_JMP, OP_SETJ, OP_SETI, OP_SETK, OP_INCJ, OP_INCI, OP_INCK:
						state_d = ST_FETCH;
					default: state_d = ST_LOAD;
				endcase
			end
			ST_LOAD: begin
				case (ins.op)
					OP_MUL:  state_d = ST_MUL;
					OP_DIV:  state_d = ST_DIV;
					OP_SQRT: state_d = ST_SQRT;
					OP_DONE: state_d = ST_OUT;
					default: state_d = ST_FETCH;
				endcase
			end
			ST_MUL:  if (cnt_q == 8'd4) state_d = ST_WB;
			ST_DIV:  if (cnt_q == 8'd127) state_d = ST_WB;
			ST_SQRT: if (cnt_q == 8'd63) state_d = ST_WB;
			ST_WB:   state_d = ST_FETCH;
			ST_OUT:  if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = state_q == ST_IDLE;
		out_valid = state_q == ST_OUT;
		tail_prob = out_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				fv_q  <= f_value;
				m_q   <= m_in;
				n_q   <= n_in;
				a1_q  <= m_in[0];
				b1_q  <= n_in[0];
				pc_q  <= '0;
				out_q <= ProbOne;
			end
			ST_FETCH: begin
				case (ins.op)
					OP_JMP:  pc_q <= cond_ok ? ins.tgt : pc_q + 1'b1;
					OP_SETJ: begin j_q <= b1_q ? 9'd3 : 9'd4; pc_q <= pc_q + 1'b1; end
					OP_SETI: begin i_q <= a1_q ? 9'd3 : 9'd4; pc_q <= pc_q + 1'b1; end
					OP_SETK: begin k_q <= '0; pc_q <= pc_q + 1'b1; end
					OP_INCJ: begin j_q <= j_q + 9'd2; pc_q <= pc_q + 1'b1; end
					OP_INCI: begin i_q <= i_q + 9'd2; pc_q <= pc_q + 1'b1; end
					OP_INCK: begin k_q <= k_q + 4'd1; pc_q <= pc_q + 1'b1; end
					default: ;
				endcase
			end
			ST_LOAD: begin
				cnt_q    <= '0;
				acc_q    <= '0;
				rem_q    <= '0;
				quo_q    <= '0;
				over_q   <= 1'b0;
				mag_a_q  <= mag(opa);
				mag_b_q  <= mag(opb);
				a_zero_q <= opa == QZero;
				neg_q    <= (mag(opb) == '0) ? opa[63] : (opa[63] ^ opb[63]);
				case (ins.op)
					OP_DIV:  dvd_q <= {24'd0, mag(opa), 40'd0};
					OP_SQRT: dvd_q <= opa[63] ? 128'd0 : {24'd0, opa, 40'd0};
					default: dvd_q <= '0;
				endcase
				case (ins.op)
					OP_ADD, OP_SUB, OP_ADDSUBK: pc_q <= pc_q + 1'b1;
					OP_CMPLE: begin flag_q <= opa <= opb; pc_q <= pc_q + 1'b1; end
					OP_DONE:  out_q <= rnd[40:9];
					default: ;
				endcase
			end
			ST_MUL: begin
				if (cnt_q < 8'd4) pp_q <= mxa * mxb;
				if (cnt_q != '0) acc_q <= acc_q + pp_sh;
				cnt_q <= cnt_q + 8'd1;
			end
			ST_DIV: begin
				rem_q  <= dge ? (dr2 - {1'b0, mag_b_q}) : dr2;
				quo_q  <= {quo_q[62:0], dge};
				over_q <= over_q | quo_q[63];
				dvd_q  <= {dvd_q[126:0], 1'b0};
				cnt_q  <= cnt_q + 8'd1;
			end
			ST_SQRT: begin
				rem_q <= sge ? 65'(sr2 - strial) : 65'(sr2);
				quo_q <= {quo_q[62:0], sge};
				dvd_q <= {dvd_q[125:0], 2'b00};
				cnt_q <= cnt_q + 8'd1;
			end
			ST_WB: pc_q <= pc_q + 1'b1;
			default: ;
		endcase
	end

endmodule

FILE: hw/rtl/fdtp_checker.sv
// fdtp_checker: port-level assertions for f_distribution_tail_probability
// depends on fdtp_pkg; bound to the top level below
module fdtp_checker
	import fdtp_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [31:0] f_value,
	input logic [7:0]  num_df,
	input logic [7:0]  den_df,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] tail_prob
);

	// zero statistic or zero degree answers one right away
	a_trivial: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (f_value == '0 || num_df == '0 || den_df == '0)
		|=> out_valid && tail_prob == ProbOne)
		else $error("trivial beat not answered with one");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> tail_prob <= ProbOne)
		else $error("tail_prob above one");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result waits");

	a_back_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> in_ready && !out_valid)
		else $error("not idle after result beat");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tail_prob))
		else $error("stalled result changed");

endmodule

bind f_distribution_tail_probability fdtp_checker u_fdtp_checker (.*);
